// File: rtl/lzsd_pkg.sv
// ----------------------------------------------------------------------------
// lzsd_pkg
// Shared types and constants of the LZSS stream decoder: window geometry,
// match limits and the command record passed from front end to back end.
// ----------------------------------------------------------------------------
package lzsd_pkg;

    localparam int WIN_AW           = 12;
    localparam int WIN_SIZE         = 1 << WIN_AW;
    localparam int MATCH_LIMIT      = 18;
    localparam int MIN_MATCH_OFFSET = 2;
    localparam int FILL_W           = WIN_AW + 1;
    localparam int UFILL_W          = 5;
    localparam int LEN_W            = 4;
    localparam int LEFT_W           = 5;

    localparam logic [WIN_AW-1:0] PTR_START  = WIN_AW'(WIN_SIZE - MATCH_LIMIT);
    localparam logic [7:0]        SPACE_CHAR = 8'h20;
    localparam logic [7:0]        ZERO_CHAR  = 8'h00;

    typedef logic [WIN_AW-1:0] win_addr_t;

    typedef enum logic [1:0] {
        CMD_LIT   = 2'd0,
        CMD_MATCH = 2'd1,
        CMD_END   = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [7:0]       lit;
        win_addr_t        pos;
        logic [LEN_W-1:0] len;
        logic             last;
    } cmd_t;

endpackage

// File: rtl/lzsd_front.sv
// ----------------------------------------------------------------------------
// lzsd_front
// Token parser: tracks flag bits and match halves, emits one command per
// literal, complete match or bare end of stream.
// ----------------------------------------------------------------------------
module lzsd_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  logic [7:0]      in_byte,
    input  logic            in_end,
    input  logic            q_full,
    output logic            in_ready,
    output logic            push,
    output lzsd_pkg::cmd_t  push_cmd
);
    import lzsd_pkg::*;

    typedef enum logic [2:0] {
        PH_FLAG  = 3'b001,
        PH_TOKEN = 3'b010,
        PH_HIGH  = 3'b100
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [8:0] flag_reg, flag_next;
    logic [7:0] held_reg, held_next;
    logic [8:0] flag_shr;
    logic       accept;
    logic       want_push;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign flag_shr = flag_reg >> 1;

    always_comb begin
        phase_next    = phase_reg;
        flag_next     = flag_reg;
        held_next     = held_reg;
        want_push     = 1'b0;
        push_cmd.kind = CMD_END;
        push_cmd.lit  = in_byte;
        push_cmd.pos  = {in_byte[7:4], held_reg};
        push_cmd.len  = in_byte[3:0];
        push_cmd.last = in_end;
        if (accept) begin
            case (phase_reg)
                PH_TOKEN: begin
                    if (flag_reg[0]) begin
                        want_push     = 1'b1;
                        push_cmd.kind = CMD_LIT;
                        if (flag_shr <= 9'd1) begin
                            flag_next  = '0;
                            phase_next = PH_FLAG;
                        end else begin
                            flag_next  = flag_shr;
                            phase_next = PH_TOKEN;
                        end
                    end else begin
                        held_next  = in_byte;
                        phase_next = PH_HIGH;
                    end
                end
                PH_HIGH: begin
                    want_push     = 1'b1;
                    push_cmd.kind = CMD_MATCH;
                    held_next     = '0;
                    if (flag_shr <= 9'd1) begin
                        flag_next  = '0;
                        phase_next = PH_FLAG;
                    end else begin
                        flag_next  = flag_shr;
                        phase_next = PH_TOKEN;
                    end
                end
                default: begin
                    flag_next  = {1'b1, in_byte};
                    phase_next = PH_TOKEN;
                end
            endcase
            // end of stream: always hand the restart to the back end
            if (in_end) begin
                want_push  = 1'b1;
                phase_next = PH_FLAG;
                flag_next  = '0;
                held_next  = '0;
            end
        end
    end

    assign push = want_push;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FLAG;
            flag_reg  <= '0;
            held_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            flag_reg  <= flag_next;
            held_reg  <= held_next;
        end
    end

endmodule

// File: rtl/lzsd_cmd_fifo.sv
// ----------------------------------------------------------------------------
// lzsd_cmd_fifo
// Small command queue between parser and copy engine.
// ----------------------------------------------------------------------------
module lzsd_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  lzsd_pkg::cmd_t  push_cmd,
    input  logic            pop,
    output lzsd_pkg::cmd_t  head_cmd,
    output logic            empty,
    output logic            full
);
    import lzsd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(DEPTH));
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/lzsd_back.sv
// ----------------------------------------------------------------------------
// lzsd_back
// Copy engine: owns the history window, runs literals and match copies one
// byte per cycle while out_ready allows, and drives the registered output stage.
// ----------------------------------------------------------------------------
module lzsd_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  lzsd_pkg::cmd_t  head_cmd,
    input  logic            q_empty,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output logic            out_last
);
    import lzsd_pkg::*;

    typedef enum logic [1:0] {
        BK_IDLE = 2'b01,
        BK_COPY = 2'b10
    } bk_state_t;

    logic [7:0] win_mem [WIN_SIZE];

    bk_state_t           state_reg, state_next;
    win_addr_t           wp_reg, wp_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [UFILL_W-1:0]  ufill_reg, ufill_next;
    win_addr_t           rd_addr_reg, rd_addr_next;
    logic [LEFT_W-1:0]   left_reg, left_next;
    logic                copy_end_reg, copy_end_next;

    logic                st1_valid_reg, st1_valid_next;
    logic                st1_fwd_reg, st1_hit_reg, st1_upper_reg;
    logic                st1_final_reg, st1_end_reg;
    logic [7:0]          fwd_data_reg;
    logic [7:0]          rd_data_reg;

    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_byte_reg, out_byte_next;
    logic                out_last_reg, out_last_next;

    logic                out_space, consume, issue, restart;
    logic                wr_en;
    logic [7:0]          wr_data;
    logic [7:0]          copy_byte;
    logic                rd_upper, rd_hit, rd_fwd;
    win_addr_t           rd_off;

    assign out_space = !out_valid_reg || out_ready;
    assign consume   = st1_valid_reg && out_space;
    assign issue     = (state_reg == BK_COPY) && (!st1_valid_reg || consume);
    assign pop       = (state_reg == BK_IDLE) && !st1_valid_reg && !q_empty
                       && ((head_cmd.kind != CMD_LIT) || out_space);

    // never-written entries read as their start value
    assign copy_byte = st1_fwd_reg ? fwd_data_reg :
                       st1_hit_reg ? rd_data_reg  :
                       (st1_upper_reg ? ZERO_CHAR : SPACE_CHAR);

    assign wr_en   = consume || (pop && (head_cmd.kind == CMD_LIT));
    assign wr_data = consume ? copy_byte : head_cmd.lit;
    assign restart = (consume && st1_final_reg && st1_end_reg)
                     || (pop && head_cmd.last && (head_cmd.kind != CMD_MATCH));

    // validity of the entry about to be read, from the fill counts
    assign rd_upper = (rd_addr_reg >= PTR_START);
    assign rd_off   = rd_addr_reg - PTR_START;
    assign rd_hit   = rd_upper ? (rd_off[UFILL_W-1:0] < ufill_reg)
                               : (({1'b0, rd_addr_reg} + FILL_W'(MATCH_LIMIT)) < fill_reg);
    assign rd_fwd   = wr_en && (wp_reg == rd_addr_reg);

    always_comb begin
        state_next     = state_reg;
        rd_addr_next   = rd_addr_reg;
        left_next      = left_reg;
        copy_end_next  = copy_end_reg;
        st1_valid_next = st1_valid_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        ufill_next     = ufill_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        if (pop && (head_cmd.kind == CMD_MATCH)) begin
            state_next    = BK_COPY;
            rd_addr_next  = head_cmd.pos;
            left_next     = LEFT_W'(head_cmd.len) + LEFT_W'(MIN_MATCH_OFFSET + 1);
            copy_end_next = head_cmd.last;
        end

        if (issue) begin
            rd_addr_next = rd_addr_reg + 1'b1;
            left_next    = left_reg - 1'b1;
            if (left_reg == LEFT_W'(1)) begin
                state_next = BK_IDLE;
            end
        end

        if (issue) begin
            st1_valid_next = 1'b1;
        end else if (consume) begin
            st1_valid_next = 1'b0;
        end

        if (consume) begin
            out_valid_next = 1'b1;
            out_byte_next  = copy_byte;
            out_last_next  = st1_final_reg && st1_end_reg;
        end else if (pop && (head_cmd.kind == CMD_LIT)) begin
            out_valid_next = 1'b1;
            out_byte_next  = head_cmd.lit;
            out_last_next  = head_cmd.last;
        end

        if (wr_en) begin
            wp_next   = wp_reg + 1'b1;
            fill_next = (fill_reg == FILL_W'(WIN_SIZE)) ? fill_reg : fill_reg + 1'b1;
            if ((fill_reg < FILL_W'(MATCH_LIMIT))
                && ((fill_reg + 1'b1) > FILL_W'(ufill_reg))) begin
                ufill_next = UFILL_W'(fill_reg + 1'b1);
            end
        end

        // back to start: pointer home, lower window reads as spaces again
        if (restart) begin
            wp_next   = PTR_START;
            fill_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            win_mem[wp_reg] <= wr_data;
        end
        if (issue) begin
            rd_data_reg <= win_mem[rd_addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            st1_fwd_reg   <= rd_fwd;
            st1_hit_reg   <= rd_hit;
            st1_upper_reg <= rd_upper;
            st1_final_reg <= (left_reg == LEFT_W'(1));
            st1_end_reg   <= copy_end_reg;
            fwd_data_reg  <= wr_data;
        end
        rd_addr_reg  <= rd_addr_next;
        left_reg     <= left_next;
        copy_end_reg <= copy_end_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            st1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            wp_reg        <= PTR_START;
            fill_reg      <= '0;
            ufill_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            st1_valid_reg <= st1_valid_next;
            out_valid_reg <= out_valid_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            ufill_reg     <= ufill_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

// File: rtl/lzss_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// lzss_stream_decoder_core
// LZSS decoder, 4096-byte history window, matches of 3 to 18 bytes.
//
//   channel  | dir | tdata                 | tlast
//   ---------+-----+-----------------------+-----------------------------
//   s_       | in  | [7:0] in_byte         | in_end: final stream byte
//   m_       | out | [7:0] out_byte        | out_last: last byte of the
//            |     |                       | transaction that ended it
//
// Flow: flag bytes and match low bytes are absorbed by the parser alone.
// A literal passes through the command queue and the output register to m_
// when the copy engine is idle; a match of N bytes (3..18) is copied one
// byte per cycle while m_tready allows, set by the single read and single
// write port of the window memory.
// Reset: no clearing pass; fill counts decide which window entries still
// read as their start value (spaces below 4078, zeros from 4078 up), and
// an end of stream only rewinds the lower fill count and the write pointer.
// Stalls: a command queue of QUEUE_DEPTH entries lets the parser keep
// taking bytes while the copy engine waits on m_tready; s_tready drops
// while the queue is full.
// ----------------------------------------------------------------------------
module lzss_stream_decoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // in_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // out_last
);
    import lzsd_pkg::*;

    cmd_t push_cmd;
    cmd_t head_cmd;
    logic push;
    logic pop;
    logic q_empty;
    logic q_full;

    // parse tokens: flag bits, literals, match halves
    lzsd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .in_end   (s_tlast),
        .q_full   (q_full),
        .in_ready (s_tready),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // hold decoded commands so either side can stall on its own
    lzsd_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (q_empty),
        .full     (q_full)
    );

    // expand literals and matches through the history window
    lzsd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_cmd  (head_cmd),
        .q_empty   (q_empty),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

// File: bench/lzss_stream_decoder_monitor.sv
// ----------------------------------------------------------------------------
// lzss_stream_decoder_monitor
// Watches both stream channels of the LZSS decoder, decodes every accepted
// input byte into the bytes it must produce, and compares each accepted
// output transaction against the oldest predicted byte.
// ----------------------------------------------------------------------------
module lzss_stream_decoder_monitor (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // in_end
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [7:0] out_byte
    input  logic       m_tlast,   // out_last
    output int         fail_count,
    output int         pending,
    output int         bytes_in,
    output int         bytes_out,
    output int         streams_done
);
    import lzsd_pkg::*;

    typedef enum logic [1:0] {
        PH_FLAG     = 2'd0,
        PH_TOKEN    = 2'd1,
        PH_MATCH_HI = 2'd2
    } parse_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_beat_t;

    logic [7:0]   hist_win [WIN_SIZE];
    win_addr_t    wr_ptr;
    logic [8:0]   ctrl_bits;
    parse_phase_t phase;
    logic [7:0]   pend_lo;

    out_beat_t    decoded_q [$];
    int           errs;
    int           in_cnt;
    int           out_cnt;
    int           end_cnt;

    // Refill spaces below the start pointer; clear the top only on reset.
    task automatic restart_window(input logic full);
        for (int i = 0; i < WIN_SIZE; i++) begin
            if (i < int'(PTR_START)) begin
                hist_win[i] = SPACE_CHAR;
            end else if (full) begin
                hist_win[i] = ZERO_CHAR;
            end
        end
        wr_ptr    = PTR_START;
        ctrl_bits = '0;
        phase     = PH_FLAG;
        pend_lo   = '0;
    endtask

    task automatic emit_byte(input logic [7:0] c, input logic last);
        decoded_q.push_back('{data: c, last: last});
        hist_win[wr_ptr] = c;
        wr_ptr = wr_ptr + 1'b1;
    endtask

    task automatic next_token();
        ctrl_bits = ctrl_bits >> 1;
        if (ctrl_bits <= 9'd1) begin
            ctrl_bits = '0;
            phase     = PH_FLAG;
        end else begin
            phase = PH_TOKEN;
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic is_end);
        win_addr_t rd;
        int        count;
        case (phase)
            PH_TOKEN: begin
                if (ctrl_bits[0]) begin
                    emit_byte(b, is_end);
                    next_token();
                end else begin
                    pend_lo = b;
                    phase   = PH_MATCH_HI;
                end
            end
            PH_MATCH_HI: begin
                rd    = {b[7:4], pend_lo};
                count = int'(b[3:0]) + MIN_MATCH_OFFSET + 1;
                // Copy one byte at a time so overlapping copies repeat.
                for (int k = 0; k < count; k++) begin
                    emit_byte(hist_win[rd], is_end && (k == count - 1));
                    rd = rd + 1'b1;
                end
                pend_lo = '0;
                next_token();
            end
            default: begin
                ctrl_bits = {1'b1, b};
                phase     = PH_TOKEN;
            end
        endcase
        if (is_end) begin
            restart_window(1'b0);
        end
    endtask

    task automatic log_error(input string what, input out_beat_t want,
                             input logic [7:0] got_d, input logic got_l);
        errs++;
        if (errs <= 10) begin
            $display("[%0t] %s: expected %02h last %0b, got %02h last %0b",
                     $time, what, want.data, want.last, got_d, got_l);
        end
    endtask

    always @(posedge aclk) begin
        out_beat_t want;
        if (!aresetn) begin
            restart_window(1'b1);
            decoded_q.delete();
            errs    = 0;
            in_cnt  = 0;
            out_cnt = 0;
            end_cnt = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata, s_tlast);
                in_cnt++;
                if (s_tlast) begin
                    end_cnt++;
                end
            end
            if (m_tvalid && m_tready) begin
                out_cnt++;
                if (decoded_q.size() == 0) begin
                    log_error("output byte with nothing predicted", '0, m_tdata, m_tlast);
                end else begin
                    want = decoded_q.pop_front();
                    if (want.data !== m_tdata || want.last !== m_tlast) begin
                        log_error("output byte mismatch", want, m_tdata, m_tlast);
                    end
                end
            end
        end
        fail_count   <= errs;
        pending      <= decoded_q.size();
        bytes_in     <= in_cnt;
        bytes_out    <= out_cnt;
        streams_done <= end_cnt;
    end

endmodule

// File: bench/lzss_stream_decoder_core_test.sv
// ----------------------------------------------------------------------------
// lzss_stream_decoder_core_test
// Stimulus and verdict for the LZSS stream decoder: a directed run through
// the token kinds and stream-end cases, then random compressed streams
// under four idling phases, a long output hold-off and drain pauses.
// ----------------------------------------------------------------------------
module lzss_stream_decoder_core_test;
    import lzsd_pkg::*;

    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 100;
    localparam int TAIL_CYCLES   = 50;
    localparam int N_DIRECTED    = 23;

    // Sender idle and receiver stall, percent per cycle, one pair per phase.
    localparam int IDLE_PCT  [4] = '{0, 59, 0, 35};
    localparam int STALL_PCT [4] = '{0, 0, 59, 35};

    // Directed bytes, {in_end, in_byte}.
    localparam logic [8:0] DIRECTED [N_DIRECTED] = '{
        9'h001,          // flag: literal, then matches
        9'h0FF,          // literal 0xff at the start pointer
        9'h0EE, 9'h0FF,  // match right behind the pointer, 18 bytes: self repeat
        9'h000, 9'h000,  // match at position 0, shortest length
        9'h0FF, 9'h0F0,  // match at the top position, wraps to 0
        9'h034, 9'h112,  // match, stream ends on the high byte
        9'h0FE,          // flag: match, then literals
        9'h0F0, 9'h0FF,  // longest match out of the area kept across ends
        9'h000, 9'h080,  // literals at the byte extremes
        9'h17F,          // literal, stream ends on a literal
        9'h1AA,          // stream ends on a flag byte: no output
        9'h000, 9'h155,  // stream ends on a match low byte: no output
        9'h0FF,          // flag: all literals
        9'h001, 9'h0A5,
        9'h15A           // last literal ends the stream
    };

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] in_byte
    logic       s_tlast  = 1'b0;    // in_end
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_byte
    logic       m_tlast;            // out_last

    int fail_count;
    int pending;
    int bytes_in;
    int bytes_out;
    int streams_done;

    int idle_pct   = 0;
    int stall_pct  = 0;
    int hold_req   = 0;
    int hold_ack   = 0;
    int sent_count = 0;

    lzss_stream_decoder_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    lzss_stream_decoder_monitor u_monitor (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .fail_count   (fail_count),
        .pending      (pending),
        .bytes_in     (bytes_in),
        .bytes_out    (bytes_out),
        .streams_done (streams_done)
    );

    initial begin
        forever begin
            #5 aclk = ~aclk;
        end
    end

    // Abort a hung run; the slowest legal run is far shorter than this.
    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    // Receiver: stall at the phase rate, or hold off for a long stretch
    // when the stimulus asks, so the block backs up into its input.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req != hold_ack) begin
                hold_ack = hold_req;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Offer one byte, idling first at the phase rate, and hold it until
    // the transaction completes. Assign s_tvalid once per clock step.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < idle_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_count++;
    endtask

    // Drop valid and wait until every predicted byte has left the block.
    // Wait for a clock edge first so the last accepted byte is already counted.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Build one well-formed stream: flag bytes followed by their tokens.
    // Track the write pointer so some matches land just behind it and
    // overlap. Now and then cut the stream on a flag or match low byte.
    task automatic send_token_stream();
        int         tokens;
        int         cut;
        int         slot;
        logic       fin;
        logic [7:0] flags;
        logic [3:0] len;
        win_addr_t  pos;
        win_addr_t  wr_est;
        tokens = $urandom_range(1, 24);
        cut    = $urandom_range(99);
        flags  = '0;
        wr_est = PTR_START;
        for (int t = 0; t < tokens; t++) begin
            slot = t % 8;
            fin  = (t == tokens - 1);
            if (slot == 0) begin
                flags = 8'($urandom);
                if (fin && cut < 8) begin
                    send_byte(flags, 1'b1);
                    return;
                end
                send_byte(flags, 1'b0);
            end
            if (flags[slot]) begin
                send_byte(8'($urandom), fin);
                wr_est = wr_est + 1'b1;
            end else begin
                len = 4'($urandom);
                case ($urandom_range(3))
                    0:       pos = wr_est - win_addr_t'($urandom_range(1, 20));
                    1:       pos = PTR_START + win_addr_t'($urandom_range(0, MATCH_LIMIT - 1));
                    default: pos = win_addr_t'($urandom);
                endcase
                if (fin && cut >= 8 && cut < 16) begin
                    send_byte(pos[7:0], 1'b1);
                    return;
                end
                send_byte(pos[7:0], 1'b0);
                send_byte({pos[11:8], len}, fin);
                wr_est = wr_est + win_addr_t'(int'(len) + MIN_MATCH_OFFSET + 1);
            end
        end
    endtask

    // Raw noise: random bytes, stray ends, always closed by an end.
    task automatic send_noise_stream();
        int n;
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
            send_byte(8'($urandom), (i == n - 1) || ($urandom_range(15) == 0));
        end
    endtask

    initial begin
        int target;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        target = N_DIRECTED;
        for (int p = 0; p < 4; p++) begin
            idle_pct  = IDLE_PCT[p];
            stall_pct <= STALL_PCT[p];
            if (p == 0) begin
                for (int i = 0; i < N_DIRECTED; i++) begin
                    send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
                end
                // Stall the output for a long stretch while bytes keep coming.
                hold_req <= hold_req + 1;
            end
            target += PHASE_ITEMS;
            while (sent_count < target) begin
                if ($urandom_range(9) == 0) begin
                    send_noise_stream();
                end else begin
                    send_token_stream();
                end
            end
            wait_drained();
        end

        // Let any late stray output show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (pending != 0) begin
            $display("%0d predicted bytes never left the block", pending);
        end
        $display("Summary: %0d compressed bytes in %0d streams decoded to %0d bytes,",
                 bytes_in, streams_done, bytes_out);
        $display("  over four idling phases with a %0d-cycle output hold-off.",
                 HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
